// ===== src/magma_pkg.sv =====
// ----------------------------------------------------------------------------
// Magma cipher package
// Shared widths, S-box table, round function helpers and interface types.
// ----------------------------------------------------------------------------
package magma_pkg;

	localparam int HALF_W      = 32;
	localparam int BLOCK_W     = 2 * HALF_W;
	localparam int NUM_KEYS    = 8;
	localparam int KEY_IDX_W   = $clog2(NUM_KEYS);
	localparam int CFG_IDX_W   = 4;
	localparam int NUM_ROUNDS  = 32;
	localparam int ROUND_W     = $clog2(NUM_ROUNDS);
	localparam int ROT_LEFT    = 11;
	localparam int NIBBLES     = HALF_W / 4;

	localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(NUM_ROUNDS - 1);

	localparam logic KIND_ENCRYPT = 1'b0;
	localparam logic KIND_DECRYPT = 1'b1;

	localparam logic [3:0] SBOX [NIBBLES][16] = '{
		'{4'd12, 4'd4, 4'd6, 4'd2, 4'd10, 4'd5, 4'd11, 4'd9,
		  4'd14, 4'd8, 4'd13, 4'd7, 4'd0, 4'd3, 4'd15, 4'd1},
		'{4'd6, 4'd8, 4'd2, 4'd3, 4'd9, 4'd10, 4'd5, 4'd12,
		  4'd1, 4'd14, 4'd4, 4'd7, 4'd11, 4'd13, 4'd0, 4'd15},
		'{4'd11, 4'd3, 4'd5, 4'd8, 4'd2, 4'd15, 4'd10, 4'd13,
		  4'd14, 4'd1, 4'd7, 4'd4, 4'd12, 4'd9, 4'd6, 4'd0},
		'{4'd12, 4'd8, 4'd2, 4'd1, 4'd13, 4'd4, 4'd15, 4'd6,
		  4'd7, 4'd0, 4'd10, 4'd5, 4'd3, 4'd14, 4'd9, 4'd11},
		'{4'd7, 4'd15, 4'd5, 4'd10, 4'd8, 4'd1, 4'd6, 4'd13,
		  4'd0, 4'd9, 4'd3, 4'd14, 4'd11, 4'd4, 4'd2, 4'd12},
		'{4'd5, 4'd13, 4'd15, 4'd6, 4'd9, 4'd2, 4'd12, 4'd10,
		  4'd11, 4'd7, 4'd8, 4'd1, 4'd4, 4'd3, 4'd14, 4'd0},
		'{4'd8, 4'd14, 4'd2, 4'd5, 4'd6, 4'd9, 4'd1, 4'd12,
		  4'd15, 4'd4, 4'd11, 4'd0, 4'd13, 4'd10, 4'd3, 4'd7},
		'{4'd1, 4'd7, 4'd14, 4'd13, 4'd0, 4'd5, 4'd8, 4'd3,
		  4'd4, 4'd15, 4'd10, 4'd6, 4'd9, 4'd12, 4'd11, 4'd2}
	};

	typedef struct packed {
		logic                 en;
		logic [CFG_IDX_W-1:0] index;
		logic [HALF_W-1:0]    data;
	} cfg_wr_t;

	typedef struct packed {
		logic [ROUND_W-1:0] round;
		logic               decrypt;
	} key_sel_t;

	function automatic logic [HALF_W-1:0] subst(input logic [HALF_W-1:0] x);
		logic [HALF_W-1:0] y;
		y = '0;
		for (int n = 0; n < NIBBLES; n++) begin
			y[4*n +: 4] = SBOX[n][x[4*n +: 4]];
		end
		return y;
	endfunction

	function automatic logic [HALF_W-1:0] rotl(input logic [HALF_W-1:0] x);
		return (x << ROT_LEFT) | (x >> (HALF_W - ROT_LEFT));
	endfunction

endpackage

// ===== src/magma_key_regs.sv =====
// ----------------------------------------------------------------------------
// Magma key register file
// Holds the eight key words and selects the round key for a given round.
// ----------------------------------------------------------------------------
module magma_key_regs
	import magma_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_wr_t           cfg_wr,
	input  key_sel_t          sel,
	output logic [HALF_W-1:0] round_key
);

	logic [HALF_W-1:0]    key_q [NUM_KEYS];
	logic [ROUND_W-1:0]   eff_round;
	logic [KEY_IDX_W-1:0] key_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_KEYS; i++) begin
				key_q[i] <= '0;
			end
		end else if (cfg_wr.en && (cfg_wr.index < CFG_IDX_W'(NUM_KEYS))) begin
			key_q[cfg_wr.index[KEY_IDX_W-1:0]] <= cfg_wr.data;
		end
	end

	// Decryption walks the encryption schedule backwards; the last eight
	// rounds of the schedule take the key words in reverse order.
	always_comb begin
		eff_round = (sel.decrypt == KIND_DECRYPT) ? ~sel.round : sel.round;
		if (eff_round[ROUND_W-1:KEY_IDX_W] == '1) begin
			key_idx = ~eff_round[KEY_IDX_W-1:0];
		end else begin
			key_idx = eff_round[KEY_IDX_W-1:0];
		end
	end

	assign round_key = key_q[key_idx];

endmodule

// ===== src/magma_round_unit.sv =====
// ----------------------------------------------------------------------------
// Magma round unit
// One Feistel round: key add, S-box layer, rotate, XOR and half swap (no swap in the last round).
// ----------------------------------------------------------------------------
module magma_round_unit
	import magma_pkg::*;
(
	input  logic [HALF_W-1:0] left,
	input  logic [HALF_W-1:0] right,
	input  logic [HALF_W-1:0] round_key,
	input  logic              last,
	output logic [HALF_W-1:0] left_next,
	output logic [HALF_W-1:0] right_next
);

	logic [HALF_W-1:0] sum;
	logic [HALF_W-1:0] f;

	always_comb begin
		sum = right + round_key;
		f   = rotl(subst(sum)) ^ left;
		if (last) begin
			left_next  = f;
			right_next = right;
		end else begin
			left_next  = right;
			right_next = f;
		end
	end

endmodule

// ===== src/magma_block_cipher_core.sv =====
// ----------------------------------------------------------------------------
// Magma block cipher core
// Iterative 64-bit Magma encrypt/decrypt engine with a 256-bit key.
// ----------------------------------------------------------------------------
// A word is accepted while the core is idle; it then runs 32 rounds, one per
// clock, through a single shared round unit, and the result is written to an
// output register. The next word is accepted only once the core is back in
// idle. The output register frees the core to take a new word while a result
// still waits; the core stalls after its last round only if the previous
// result has not been taken yet. Key words are written through the
// configuration port at indexes 0 to 7, writes to other indexes are dropped,
// and keys must only change while the core is idle.
// ----------------------------------------------------------------------------
module magma_block_cipher_core
	import magma_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [HALF_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [BLOCK_W-1:0]   block_in,
	input  logic                 kind,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [BLOCK_W-1:0]   block_out
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_WAIT = 3'b100
	} state_t;

	state_t             state_q;
	logic [ROUND_W-1:0] round_q;
	logic [HALF_W-1:0]  left_q;
	logic [HALF_W-1:0]  right_q;
	logic               mode_q;
	logic               out_valid_q;
	logic [BLOCK_W-1:0] out_q;

	cfg_wr_t            cfg_wr;
	key_sel_t           key_sel;
	logic [HALF_W-1:0]  round_key;
	logic [HALF_W-1:0]  left_next;
	logic [HALF_W-1:0]  right_next;
	logic               last_round;
	logic               in_fire;
	logic               slot_free;
	logic               result_load;

	assign cfg_ready    = 1'b1;
	assign cfg_wr.en    = cfg_valid && cfg_ready;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	assign key_sel.round   = round_q;
	assign key_sel.decrypt = mode_q;

	assign last_round  = (round_q == LAST_ROUND);
	assign in_ready    = (state_q == ST_IDLE);
	assign in_fire     = in_valid && in_ready;
	assign slot_free   = !out_valid_q || out_ready;
	assign result_load = ((state_q == ST_RUN) && last_round && slot_free) ||
	                     ((state_q == ST_WAIT) && slot_free);
	assign out_valid   = out_valid_q;
	assign block_out   = out_q;

	magma_key_regs u_keys (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.sel       (key_sel),
		.round_key (round_key)
	);

	magma_round_unit u_round (
		.left       (left_q),
		.right      (right_q),
		.round_key  (round_key),
		.last       (last_round),
		.left_next  (left_next),
		.right_next (right_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			round_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (result_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_RUN;
						round_q <= '0;
					end
				end
				ST_RUN: begin
					if (last_round) begin
						round_q <= '0;
						if (slot_free) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_WAIT;
						end
					end else begin
						round_q <= round_q + ROUND_W'(1);
					end
				end
				ST_WAIT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			left_q  <= block_in[BLOCK_W-1:HALF_W];
			right_q <= block_in[HALF_W-1:0];
			mode_q  <= kind;
		end else if (state_q == ST_RUN) begin
			left_q  <= left_next;
			right_q <= right_next;
		end
		if (result_load) begin
			if (state_q == ST_RUN) begin
				out_q <= {left_next, right_next};
			end else begin
				out_q <= {left_q, right_q};
			end
		end
	end

	a_start_round0: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == ST_RUN) && (round_q == '0))
		else $error("round counter did not start at zero");

	a_round_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) && !last_round |=>
		(state_q == ST_RUN) && (round_q == $past(round_q) + ROUND_W'(1)))
		else $error("round counter skipped or left the run state early");

	a_wait_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAIT) |-> out_valid_q)
		else $error("waiting for the output slot while it is empty");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |->
		($past(state_q) == ST_WAIT) || ($past(state_q) == ST_RUN && $past(last_round)))
		else $error("result word appeared without a finished block");

	a_idle_round: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_RUN) |-> (round_q == '0))
		else $error("round counter not cleared outside the run state");

endmodule
